>>> rtl/rbss_pkg.sv
// ----------------------------------------------------------------------------
// rbss_pkg
// Shared types, constants, microcode table and generator step for the
// random backoff send scheduler.
// ----------------------------------------------------------------------------
package rbss_pkg;

    localparam int TIME_W  = 16;
    localparam int RNG_W   = 32;
    localparam int DVS_W   = TIME_W + 1;
    localparam int CNT_W   = $clog2(RNG_W);
    localparam int STEP_W  = 4;
    localparam int CIDX_W  = 2;
    localparam int IN_DW   = 40;
    localparam int OUT_DW  = 40;

    localparam logic [TIME_W-1:0] MIN_RST   = TIME_W'(500);
    localparam logic [TIME_W-1:0] MAX_RST   = TIME_W'(3000);
    localparam logic [TIME_W-1:0] GUARD_RST = TIME_W'(2000);
    localparam logic [RNG_W-1:0]  SEED_RST  = RNG_W'(1);
    localparam logic [TIME_W-1:0] TIME_SAT  = '1;

    localparam logic [CIDX_W-1:0] REG_MIN   = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_MAX   = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] REG_GUARD = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_SEED  = CIDX_W'(3);

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_PUBLISH = 1'b1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_TICK,
        OP_PUB,
        OP_DRAW,
        OP_ADD_REM,
        OP_SEND,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_KIND_PUB,
        C_NOT_PENDING,
        C_BL_NONZERO,
        C_BL_ZERO,
        C_GUARD_MET,
        C_DIV_BUSY,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic item_valid;
        logic kind_pub;
        logic pending;
        logic bl_zero;
        logic guard_met;
        logic div_busy;
        logic out_full;
    } status_t;

    localparam logic [STEP_W-1:0] S_WAIT   = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_CHECK  = STEP_W'(4);
    localparam logic [STEP_W-1:0] S_WAIT_A = STEP_W'(6);
    localparam logic [STEP_W-1:0] S_PUB    = STEP_W'(8);
    localparam logic [STEP_W-1:0] S_WAIT_B = STEP_W'(10);
    localparam logic [STEP_W-1:0] S_SEND   = STEP_W'(14);
    localparam logic [STEP_W-1:0] S_EMIT   = STEP_W'(15);

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] addr);
        ctrl_t w;
        begin
            unique case (addr)
                4'd0:    w = '{OP_ACCEPT,  C_NO_ITEM,     S_WAIT};
                4'd1:    w = '{OP_NOP,     C_KIND_PUB,    S_PUB};
                4'd2:    w = '{OP_TICK,    C_NOT_PENDING, S_EMIT};
                4'd3:    w = '{OP_NOP,     C_BL_NONZERO,  S_EMIT};
                4'd4:    w = '{OP_NOP,     C_GUARD_MET,   S_SEND};
                4'd5:    w = '{OP_DRAW,    C_NEVER,       S_WAIT};
                4'd6:    w = '{OP_NOP,     C_DIV_BUSY,    S_WAIT_A};
                4'd7:    w = '{OP_ADD_REM, C_ALWAYS,      S_EMIT};
                4'd8:    w = '{OP_PUB,     C_NEVER,       S_WAIT};
                4'd9:    w = '{OP_DRAW,    C_NEVER,       S_WAIT};
                4'd10:   w = '{OP_NOP,     C_DIV_BUSY,    S_WAIT_B};
                4'd11:   w = '{OP_ADD_REM, C_NEVER,       S_WAIT};
                4'd12:   w = '{OP_NOP,     C_BL_ZERO,     S_CHECK};
                4'd13:   w = '{OP_NOP,     C_ALWAYS,      S_EMIT};
                4'd14:   w = '{OP_SEND,    C_NEVER,       S_WAIT};
                4'd15:   w = '{OP_EMIT,    C_OUT_FULL,    S_EMIT};
                default: w = '{OP_NOP,     C_ALWAYS,      S_WAIT};
            endcase
            return w;
        end
    endfunction

    function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] x);
        logic [RNG_W-1:0] a;
        logic [RNG_W-1:0] b;
        begin
            a = x ^ (x << 13);
            b = a ^ (a >> 17);
            return b ^ (b << 5);
        end
    endfunction

endpackage

>>> rtl/random_backoff_send_scheduler_top.sv
// ----------------------------------------------------------------------------
// random_backoff_send_scheduler_top
// Random backoff send scheduler with a microcoded control sequencer.
//
//  channel   direction  tdata (low bit up)                          tuser
//  s_axis    in         line_idle, stamp, 7 zero bits               kind
//  m_axis    out        send_now, sent_stamp, still_pending,        -
//                       6 zero bits
//  cfg       in         cfg_index selects register, cfg_data value  -
//
//  A draw that needs a random number waits on the remainder unit, which
//  resolves one dividend bit per cycle; a publish request may draw twice.
//  Reset loads the register defaults and seeds the generator with 1.
//  The next item is taken while a result waits; a stalled output holds
//  the sequencer at its emit step.
// ----------------------------------------------------------------------------
module random_backoff_send_scheduler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rbss_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [rbss_pkg::RNG_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rbss_pkg::IN_DW-1:0]    s_axis_tdata,  // line_idle, stamp
    input  logic                          s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rbss_pkg::OUT_DW-1:0]   m_axis_tdata   // send_now, sent_stamp, still_pending
);

    rbss_pkg::ctrl_t   ctrl;
    rbss_pkg::status_t status;

    rbss_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    rbss_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> rtl/rbss_seq.sv
// ----------------------------------------------------------------------------
// rbss_seq
// Microcode sequencer: step counter, control store and jump conditions.
// ----------------------------------------------------------------------------
module rbss_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  rbss_pkg::status_t status,
    output rbss_pkg::ctrl_t   ctrl
);

    logic [rbss_pkg::STEP_W-1:0] step_reg;
    logic [rbss_pkg::STEP_W-1:0] step_next;
    logic                        take;

    assign ctrl = rbss_pkg::ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            rbss_pkg::C_NEVER:       take = 1'b0;
            rbss_pkg::C_ALWAYS:      take = 1'b1;
            rbss_pkg::C_NO_ITEM:     take = !status.item_valid;
            rbss_pkg::C_KIND_PUB:    take = status.kind_pub;
            rbss_pkg::C_NOT_PENDING: take = !status.pending;
            rbss_pkg::C_BL_NONZERO:  take = !status.bl_zero;
            rbss_pkg::C_BL_ZERO:     take = status.bl_zero;
            rbss_pkg::C_GUARD_MET:   take = status.guard_met;
            rbss_pkg::C_DIV_BUSY:    take = status.div_busy;
            rbss_pkg::C_OUT_FULL:    take = status.out_full;
            default:                 take = 1'b0;
        endcase
        step_next = take ? ctrl.target : step_reg + rbss_pkg::STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= rbss_pkg::S_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

>>> rtl/rbss_mod.sv
// ----------------------------------------------------------------------------
// rbss_mod
// Iterative restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rbss_mod (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rbss_pkg::RNG_W-1:0]   dividend,
    input  logic [rbss_pkg::DVS_W-1:0]   divisor,
    output logic                         busy,
    output logic [rbss_pkg::TIME_W-1:0]  rem
);

    logic [rbss_pkg::RNG_W-1:0]  quo_reg;
    logic [rbss_pkg::TIME_W-1:0] rem_reg;
    logic [rbss_pkg::DVS_W-1:0]  dvs_reg;
    logic [rbss_pkg::CNT_W-1:0]  cnt_reg;
    logic                        busy_reg;
    logic [rbss_pkg::DVS_W-1:0]  trial;
    logic [rbss_pkg::DVS_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[rbss_pkg::RNG_W-1]};
        rem_next = (trial >= dvs_reg) ? trial - dvs_reg : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + rbss_pkg::CNT_W'(1);
            if (cnt_reg == rbss_pkg::CNT_W'(rbss_pkg::RNG_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_reg << 1;
            rem_reg <= rem_next[rbss_pkg::TIME_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

>>> rtl/rbss_dp.sv
// ----------------------------------------------------------------------------
// rbss_dp
// Datapath: configuration, scheduler state, generator and output register.
// ----------------------------------------------------------------------------
module rbss_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbss_pkg::ctrl_t               ctrl,
    output rbss_pkg::status_t             status,
    input  logic                          cfg_we,
    input  logic [rbss_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [rbss_pkg::RNG_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rbss_pkg::IN_DW-1:0]    s_axis_tdata,
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rbss_pkg::OUT_DW-1:0]   m_axis_tdata
);

    logic [rbss_pkg::TIME_W-1:0] min_reg;
    logic [rbss_pkg::TIME_W-1:0] max_reg;
    logic [rbss_pkg::TIME_W-1:0] guard_reg;
    logic [rbss_pkg::RNG_W-1:0]  rng_reg;
    logic                        pending_reg;
    logic [rbss_pkg::TIME_W-1:0] bl_reg;
    logic [rbss_pkg::TIME_W-1:0] idle_reg;
    logic                        rand_reg;
    logic                        sent_reg;
    logic                        kind_reg;
    logic                        lidle_reg;
    logic [rbss_pkg::RNG_W-1:0]  uptime_reg;
    logic                        out_valid_reg;
    logic [rbss_pkg::OUT_DW-1:0] out_data_reg;

    logic                        span_pos;
    logic [rbss_pkg::DVS_W-1:0]  divisor;
    logic [rbss_pkg::RNG_W-1:0]  rng_next;
    logic                        div_start;
    logic                        div_busy;
    logic [rbss_pkg::TIME_W-1:0] div_rem;
    logic                        out_full;
    logic                        in_xfer;
    logic [rbss_pkg::RNG_W-1:0]  sent_up;

    assign span_pos  = max_reg > min_reg;
    assign divisor   = {1'b0, max_reg} - {1'b0, min_reg} + rbss_pkg::DVS_W'(1);
    assign rng_next  = rbss_pkg::xorshift(rng_reg);
    assign div_start = (ctrl.op == rbss_pkg::OP_DRAW) && span_pos;
    assign out_full  = out_valid_reg && !m_axis_tready;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign sent_up   = sent_reg ? uptime_reg : '0;

    assign s_axis_tready = (ctrl.op == rbss_pkg::OP_ACCEPT);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign status = '{
        item_valid: s_axis_tvalid,
        kind_pub:   kind_reg == rbss_pkg::KIND_PUBLISH,
        pending:    pending_reg,
        bl_zero:    bl_reg == '0,
        guard_met:  idle_reg >= guard_reg,
        div_busy:   div_busy,
        out_full:   out_full
    };

    rbss_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rng_next),
        .divisor  (divisor),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= rbss_pkg::MIN_RST;
            max_reg       <= rbss_pkg::MAX_RST;
            guard_reg     <= rbss_pkg::GUARD_RST;
            rng_reg       <= rbss_pkg::SEED_RST | rbss_pkg::RNG_W'(1);
            pending_reg   <= 1'b0;
            bl_reg        <= '0;
            idle_reg      <= '0;
            rand_reg      <= 1'b0;
            sent_reg      <= 1'b0;
            kind_reg      <= rbss_pkg::KIND_TICK;
            lidle_reg     <= 1'b0;
            uptime_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && (ctrl.op != rbss_pkg::OP_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (ctrl.op)
                rbss_pkg::OP_ACCEPT:
                begin
                    if (in_xfer)
                    begin
                        kind_reg   <= s_axis_tuser;
                        lidle_reg  <= s_axis_tdata[0];
                        uptime_reg <= s_axis_tdata[rbss_pkg::RNG_W:1];
                        sent_reg   <= 1'b0;
                    end
                end
                rbss_pkg::OP_TICK:
                begin
                    if (!lidle_reg)
                    begin
                        idle_reg <= '0;
                    end
                    else if (idle_reg != rbss_pkg::TIME_SAT)
                    begin
                        idle_reg <= idle_reg + rbss_pkg::TIME_W'(1);
                    end
                    if (pending_reg && (bl_reg != '0))
                    begin
                        bl_reg <= bl_reg - rbss_pkg::TIME_W'(1);
                    end
                end
                rbss_pkg::OP_PUB:
                begin
                    pending_reg <= 1'b1;
                end
                rbss_pkg::OP_DRAW:
                begin
                    bl_reg   <= min_reg;
                    rand_reg <= span_pos;
                    if (span_pos)
                    begin
                        rng_reg <= rng_next;
                    end
                end
                rbss_pkg::OP_ADD_REM:
                begin
                    if (rand_reg)
                    begin
                        bl_reg <= bl_reg + div_rem;
                    end
                end
                rbss_pkg::OP_SEND:
                begin
                    pending_reg <= 1'b0;
                    sent_reg    <= 1'b1;
                end
                rbss_pkg::OP_EMIT:
                begin
                    if (!out_full)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= rbss_pkg::OUT_DW'({pending_reg, sent_up, sent_reg});
                    end
                end
                default:
                begin
                end
            endcase

            if (cfg_we)
            begin
                unique case (cfg_index)
                    rbss_pkg::REG_MIN:   min_reg   <= cfg_data[rbss_pkg::TIME_W-1:0];
                    rbss_pkg::REG_MAX:   max_reg   <= cfg_data[rbss_pkg::TIME_W-1:0];
                    rbss_pkg::REG_GUARD: guard_reg <= cfg_data[rbss_pkg::TIME_W-1:0];
                    rbss_pkg::REG_SEED:  rng_reg   <= cfg_data | rbss_pkg::RNG_W'(1);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    a_sent_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[rbss_pkg::RNG_W+1]))
        else $error("result marks a send while still pending");

    a_unsent_zero_uptime: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[rbss_pkg::RNG_W:1] == '0))
        else $error("uptime carried without a send");

    a_rem_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == rbss_pkg::OP_ADD_REM) |-> !div_busy)
        else $error("remainder taken while modulo unit busy");

    a_draw_starts: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("modulo unit did not start on a random draw");

    a_rng_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rng_reg[0] || $past(rng_reg) != '0 || $past(div_start))
        else $error("generator state lost its seed bit unexpectedly");

endmodule
